### hdl/hslb_pkg.sv
// Shared types, constants and fixed-point helpers for the saturation layer blend unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hslb_pkg;

   // Channel width; the all-ones code stands for 1.0.
   localparam int CHANNEL_BITS = 16;
   localparam logic [CHANNEL_BITS-1:0] FULL = '1;

   // FULL/2 widened to a product's width, the rounding term for fraction products.
   localparam logic [2*CHANNEL_BITS-1:0] HALF_WIDE =
      {{(CHANNEL_BITS+1){1'b0}}, {(CHANNEL_BITS-1){1'b1}}};

   // Stage counts of the units; the divider has an overflow stage and one stage a bit.
   localparam int ALPHA_LAT = 4;
   localparam int DIV_LAT   = CHANNEL_BITS + 1;
   localparam int REMAP_LAT = 3;
   localparam int MIX_LAT   = 3;
   localparam int PIPE_LAT  = ALPHA_LAT + DIV_LAT + REMAP_LAT + DIV_LAT + MIX_LAT;

   typedef logic [CHANNEL_BITS-1:0]   chan_type;
   typedef logic [2*CHANNEL_BITS-1:0] wide_type;

   // Base pixel with its run marker, carried to the output unchanged.
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
      logic     last;
   } pix_type;

   // Context leaving the alpha unit.
   typedef struct packed {
      pix_type  base;
      chan_type bmax;
      chan_type bmin;
      chan_type lmax;
      chan_type lmin;
   } alpha_ctx_type;

   // Context carried beside the ratio and saturation dividers.
   typedef struct packed {
      pix_type  base;
      chan_type bmax;
      chan_type bmin;
      logic     blend;
   } sat_ctx_type;

   // Context carried beside the remap dividers into the mixer.
   typedef struct packed {
      pix_type  base;
      chan_type bmax;
      chan_type lo;
      chan_type ratio;
      logic     grey;
   } mix_ctx_type;

   // Floor division of a double-width value by FULL: a shift, a fold and two corrections.
   function automatic chan_type div_full(input wide_type y);
      logic [CHANNEL_BITS:0]   q;
      logic [CHANNEL_BITS+1:0] r;
      q = {1'b0, y[2*CHANNEL_BITS-1:CHANNEL_BITS]};
      r = {2'b00, y[CHANNEL_BITS-1:0]} + {2'b00, y[2*CHANNEL_BITS-1:CHANNEL_BITS]};
      if (r >= {2'b00, FULL}) begin
         q = q + 1'b1;
         r = r - {2'b00, FULL};
      end
      if (r >= {2'b00, FULL}) begin
         q = q + 1'b1;
      end
      return q[CHANNEL_BITS-1:0];
   endfunction

   // Rounded fraction from a registered product of two fractions.
   function automatic chan_type frac_round(input wide_type p);
      return div_full(p + HALF_WIDE);
   endfunction

   function automatic chan_type max3(input chan_type a, input chan_type b, input chan_type c);
      chan_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic chan_type min3(input chan_type a, input chan_type b, input chan_type c);
      chan_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

`default_nettype wire

### hdl/hslb_div.sv
// Pipelined restoring divider: double-width numerator over a channel-wide divisor.
// Quotients of 1.0 or more saturate to FULL. Depends on hslb_pkg.
`default_nettype none

module hslb_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  hslb_pkg::wide_type in_num,
   input  hslb_pkg::chan_type in_den,
   output logic               out_valid,
   output hslb_pkg::chan_type out_quot
);
   import hslb_pkg::*;

   localparam int LAST = DIV_LAT - 1;

   logic [DIV_LAT-1:0] valid_ff;
   logic [DIV_LAT-1:0] valid_in;
   logic [DIV_LAT-1:0] ovf_ff;
   logic [DIV_LAT-1:0] ovf_in;
   wide_type           rem_ff  [DIV_LAT];
   wide_type           rem_in  [DIV_LAT];
   chan_type           den_ff  [DIV_LAT];
   chan_type           den_in  [DIV_LAT];
   chan_type           quot_ff [DIV_LAT];
   chan_type           quot_in [DIV_LAT];

   // Stage 0 checks for overflow; each later stage settles one quotient bit, MSB first.
   always_comb begin
      wide_type d_sh;
      valid_in[0] = in_valid;
      rem_in[0]   = in_num;
      den_in[0]   = in_den;
      quot_in[0]  = '0;
      ovf_in[0]   = (in_num >= {in_den, {CHANNEL_BITS{1'b0}}});
      d_sh        = '0;
      for (int k = 1; k < DIV_LAT; k++) begin
         valid_in[k] = valid_ff[k-1];
         den_in[k]   = den_ff[k-1];
         ovf_in[k]   = ovf_ff[k-1];
         d_sh        = {{CHANNEL_BITS{1'b0}}, den_ff[k-1]} << (LAST - k);
         if (rem_ff[k-1] >= d_sh) begin
            rem_in[k]  = rem_ff[k-1] - d_sh;
            quot_in[k] = {quot_ff[k-1][CHANNEL_BITS-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_ff[k-1];
            quot_in[k] = {quot_ff[k-1][CHANNEL_BITS-2:0], 1'b0};
         end
      end
   end

   // Stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      ovf_ff  <= ovf_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff[LAST];
   assign out_quot  = ovf_ff[LAST] ? FULL : quot_ff[LAST];

endmodule

`default_nettype wire

### hdl/hslb_alpha.sv
// Alpha unit: composite alpha, new alpha and the channel extremes, in four stages.
// Depends on hslb_pkg.
`default_nettype none

module hslb_alpha (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  hslb_pkg::pix_type       in_base,
   input  hslb_pkg::chan_type      in_layer_red,
   input  hslb_pkg::chan_type      in_layer_green,
   input  hslb_pkg::chan_type      in_layer_blue,
   input  hslb_pkg::chan_type      in_layer_alpha,
   input  hslb_pkg::chan_type      in_mask,
   input  hslb_pkg::chan_type      opacity,
   input  logic                    mask_enable,
   output logic                    out_valid,
   output hslb_pkg::chan_type      out_comp,
   output hslb_pkg::chan_type      out_nalpha,
   output hslb_pkg::alpha_ctx_type out_ctx
);
   import hslb_pkg::*;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   alpha_ctx_type s1_ctx_ff, s2_ctx_ff, s3_ctx_ff, s4_ctx_ff;
   alpha_ctx_type s1_ctx_in;
   chan_type      s1_mask_ff;
   chan_type      mina;
   wide_type      s1_prod_ff, s1_prod_in;
   chan_type      s2_comp_ff, s2_comp_in;
   wide_type      s2_prod_ff, s2_prod_in;
   chan_type      s3_comp_ff, s3_comp_in;
   wide_type      s3_prod_ff, s3_prod_in;
   chan_type      s4_comp_ff;
   chan_type      s4_nalpha_ff, s4_nalpha_in;

   // Stage 1: smaller alpha times opacity, and the extremes of both colors.
   always_comb begin
      mina           = (in_base.alpha < in_layer_alpha) ? in_base.alpha : in_layer_alpha;
      s1_prod_in     = wide_type'(mina) * wide_type'(opacity);
      s1_ctx_in.base = in_base;
      s1_ctx_in.bmax = max3(in_base.red, in_base.green, in_base.blue);
      s1_ctx_in.bmin = min3(in_base.red, in_base.green, in_base.blue);
      s1_ctx_in.lmax = max3(in_layer_red, in_layer_green, in_layer_blue);
      s1_ctx_in.lmin = min3(in_layer_red, in_layer_green, in_layer_blue);
   end

   // Stage 2: round, then multiply by the mask.
   assign s2_comp_in = frac_round(s1_prod_ff);
   assign s2_prod_in = wide_type'(s2_comp_in) * wide_type'(s1_mask_ff);

   // Stage 3: apply the mask when enabled; start the new-alpha product.
   assign s3_comp_in = mask_enable ? frac_round(s2_prod_ff) : s2_comp_ff;
   assign s3_prod_in = wide_type'(FULL - s2_ctx_ff.base.alpha) * wide_type'(s3_comp_in);

   // Stage 4: new alpha.
   assign s4_nalpha_in = s3_ctx_ff.base.alpha + frac_round(s3_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_ctx_ff    <= s1_ctx_in;
      s1_mask_ff   <= in_mask;
      s1_prod_ff   <= s1_prod_in;
      s2_ctx_ff    <= s1_ctx_ff;
      s2_comp_ff   <= s2_comp_in;
      s2_prod_ff   <= s2_prod_in;
      s3_ctx_ff    <= s2_ctx_ff;
      s3_comp_ff   <= s3_comp_in;
      s3_prod_ff   <= s3_prod_in;
      s4_ctx_ff    <= s3_ctx_ff;
      s4_comp_ff   <= s3_comp_ff;
      s4_nalpha_ff <= s4_nalpha_in;
   end

   assign out_valid  = s4_valid_ff;
   assign out_comp   = s4_comp_ff;
   assign out_nalpha = s4_nalpha_ff;
   assign out_ctx    = s4_ctx_ff;

endmodule

`default_nettype wire

### hdl/hslb_mix.sv
// Mixer: builds the recolored channels and blends them with the base by the ratio.
// Three stages, the last one being the result register. Depends on hslb_pkg.
`default_nettype none

module hslb_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  hslb_pkg::mix_ctx_type      in_ctx,
   input  hslb_pkg::chan_type [2:0]   in_quot,
   output logic                       out_valid,
   output hslb_pkg::pix_type          out_pix
);
   import hslb_pkg::*;

   logic               m1_valid_ff, m2_valid_ff, m3_valid_ff;
   pix_type            m1_pix_ff, m2_pix_ff, m3_pix_ff;
   chan_type [2:0]     base_ch;
   chan_type [2:0]     hsv;
   wide_type [2:0]     m1_pa_ff, m1_pa_in;
   wide_type [2:0]     m1_pb_ff, m1_pb_in;
   wide_type [2:0]     m2_sum_ff, m2_sum_in;
   pix_type            m3_pix_in;
   chan_type           inv_ratio;

   // Stage 1: recolored channel, then both blend products.
   always_comb begin
      base_ch   = {in_ctx.base.blue, in_ctx.base.green, in_ctx.base.red};
      inv_ratio = FULL - in_ctx.ratio;
      for (int i = 0; i < 3; i++) begin
         if (in_ctx.grey) begin
            // A grey base takes hue red: red at the maximum, the others at the new minimum.
            hsv[i] = (i == 0) ? in_ctx.bmax : in_ctx.lo;
         end else begin
            hsv[i] = in_ctx.lo + in_quot[i];
         end
         m1_pa_in[i] = wide_type'(hsv[i]) * wide_type'(in_ctx.ratio);
         m1_pb_in[i] = wide_type'(base_ch[i]) * wide_type'(inv_ratio);
      end
   end

   // Stage 2: sum with the rounding term.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m2_sum_in[i] = m1_pa_ff[i] + m1_pb_ff[i] + HALF_WIDE;
      end
   end

   // Stage 3: scale back to a fraction.
   always_comb begin
      m3_pix_in       = m2_pix_ff;
      m3_pix_in.red   = div_full(m2_sum_ff[0]);
      m3_pix_in.green = div_full(m2_sum_ff[1]);
      m3_pix_in.blue  = div_full(m2_sum_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
      m1_pix_ff <= in_ctx.base;
      m1_pa_ff  <= m1_pa_in;
      m1_pb_ff  <= m1_pb_in;
      m2_pix_ff <= m1_pix_ff;
      m2_sum_ff <= m2_sum_in;
      m3_pix_ff <= m3_pix_in;
   end

   assign out_valid = m3_valid_ff;
   assign out_pix   = m3_pix_ff;

endmodule

`default_nettype wire

### hdl/hsv_saturation_layer_blend_unit.sv
// Saturation layer blend unit, one RGBA pixel a cycle.
//
// Input: a pixel transfer is taken at each rising edge where start is high and
// busy is low. busy is high only while reset is held, so one pixel can enter
// in every cycle. Result: rsp_valid marks each result for exactly one cycle,
// in input order; the receiver cannot stall and no handshake flows back.
// The pipeline has 4 alpha stages, a 17-stage ratio and saturation divider,
// 3 remap stages, a 17-stage remap divider and 3 blend stages. Throughput
// is one pixel a cycle; the divider depth, one quotient bit a stage, sets
// most of the latency.
// Reset empties the pipeline, drops pixels in flight, sets opacity to 1.0
// and turns the mask off. Registers sit at byte address 0 (opacity) and
// 4 (mask enable) on the APB-style port; write them only while idle.
// Depends on hslb_pkg, hslb_alpha, hslb_div and hslb_mix.
`default_nettype none

module hsv_saturation_layer_blend_unit (
   input  logic        clock,
   input  logic        reset,
   // Pixel input.
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_base_red,
   input  logic [15:0] req_base_green,
   input  logic [15:0] req_base_blue,
   input  logic [15:0] req_base_alpha,
   input  logic [15:0] req_layer_red,
   input  logic [15:0] req_layer_green,
   input  logic [15:0] req_layer_blue,
   input  logic [15:0] req_layer_alpha,
   input  logic [15:0] req_mask_value,
   input  logic        req_end_of_run,
   // Result output.
   output logic        rsp_valid,
   output logic [15:0] rsp_result_red,
   output logic [15:0] rsp_result_green,
   output logic [15:0] rsp_result_blue,
   output logic [15:0] rsp_result_alpha,
   output logic        rsp_run_last,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import hslb_pkg::*;

   localparam logic REG_OPACITY = 1'b0;
   localparam logic REG_MASK    = 1'b1;

   // ---------------------------------------------------------------- registers
   chan_type opacity_ff;
   logic     mask_en_ff;
   logic     csr_write;
   logic     csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= FULL;
         mask_en_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OPACITY: opacity_ff <= pwdata[CHANNEL_BITS-1:0];
            REG_MASK:    mask_en_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read data follows the address.
   always_comb begin
      unique case (csr_index)
         REG_OPACITY: prdata = {{(32-CHANNEL_BITS){1'b0}}, opacity_ff};
         REG_MASK:    prdata = {31'b0, mask_en_ff};
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- alpha
   logic          accept;
   pix_type       req_base;
   logic          a_valid;
   chan_type      a_comp;
   chan_type      a_nalpha;
   alpha_ctx_type a_ctx;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign req_base = '{red: req_base_red, green: req_base_green, blue: req_base_blue,
                       alpha: req_base_alpha, last: req_end_of_run};

   hslb_alpha u_alpha (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_base        (req_base),
      .in_layer_red   (req_layer_red),
      .in_layer_green (req_layer_green),
      .in_layer_blue  (req_layer_blue),
      .in_layer_alpha (req_layer_alpha),
      .in_mask        (req_mask_value),
      .opacity        (opacity_ff),
      .mask_enable    (mask_en_ff),
      .out_valid      (a_valid),
      .out_comp       (a_comp),
      .out_nalpha     (a_nalpha),
      .out_ctx        (a_ctx)
   );

   // ---------------------------------------------------------------- ratio and saturation
   wide_type    rat_num, sat_num;
   chan_type    rat_den, sat_den;
   chan_type    lspan;
   logic        rat_valid, sat_valid;
   chan_type    rat_quot, sat_quot;
   sat_ctx_type sctx_in;
   sat_ctx_type sctx_ff [DIV_LAT];

   always_comb begin
      // Ratio = comp * FULL / new alpha, rounded.
      rat_num = (wide_type'(a_comp) << CHANNEL_BITS) - wide_type'(a_comp)
                + wide_type'(a_nalpha >> 1);
      rat_den = (a_nalpha == '0) ? chan_type'(1) : a_nalpha;
      // Layer saturation = (max - min) * FULL / max, zero for a black layer.
      lspan   = a_ctx.lmax - a_ctx.lmin;
      if (a_ctx.lmax == '0) begin
         sat_num = '0;
         sat_den = chan_type'(1);
      end else begin
         sat_num = (wide_type'(lspan) << CHANNEL_BITS) - wide_type'(lspan)
                   + wide_type'(a_ctx.lmax >> 1);
         sat_den = a_ctx.lmax;
      end
      sctx_in.base  = a_ctx.base;
      sctx_in.bmax  = a_ctx.bmax;
      sctx_in.bmin  = a_ctx.bmin;
      sctx_in.blend = (a_comp != '0) && (a_nalpha != '0);
   end

   hslb_div u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_num    (rat_num),
      .in_den    (rat_den),
      .out_valid (rat_valid),
      .out_quot  (rat_quot)
   );

   hslb_div u_div_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_num    (sat_num),
      .in_den    (sat_den),
      .out_valid (sat_valid),
      .out_quot  (sat_quot)
   );

   // Context travels beside the dividers.
   always_ff @(posedge clock) begin
      sctx_ff[0] <= sctx_in;
      for (int k = 1; k < DIV_LAT; k++) begin
         sctx_ff[k] <= sctx_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- remap setup
   logic           l1_valid_ff, l2_valid_ff, l3_valid_ff;
   sat_ctx_type    l1_ctx_ff;
   chan_type       l1_ratio_ff;
   wide_type       l1_prod_ff;
   mix_ctx_type    l2_ctx_ff, l2_ctx_in;
   chan_type       l2_bmin_ff;
   chan_type       l2_nspan_ff;
   mix_ctx_type    l3_ctx_ff;
   wide_type [2:0] l3_prod_ff, l3_prod_in;
   chan_type       l3_span_ff;
   chan_type [2:0] l2_ch;

   // Stage L2: new minimum lo = V - V*s, and the new span V - lo.
   always_comb begin
      l2_ctx_in.base  = l1_ctx_ff.base;
      l2_ctx_in.bmax  = l1_ctx_ff.bmax;
      l2_ctx_in.lo    = l1_ctx_ff.bmax - frac_round(l1_prod_ff);
      l2_ctx_in.ratio = l1_ratio_ff;
      l2_ctx_in.grey  = (l1_ctx_ff.bmax == l1_ctx_ff.bmin);
   end

   // Stage L3: new span times each channel's offset above the minimum.
   always_comb begin
      l2_ch = {l2_ctx_ff.base.blue, l2_ctx_ff.base.green, l2_ctx_ff.base.red};
      for (int i = 0; i < 3; i++) begin
         l3_prod_in[i] = wide_type'(l2_nspan_ff) * wide_type'(l2_ch[i] - l2_bmin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
         l3_valid_ff <= 1'b0;
      end else begin
         l1_valid_ff <= rat_valid & sat_valid;
         l2_valid_ff <= l1_valid_ff;
         l3_valid_ff <= l2_valid_ff;
      end
      // Stage L1: ratio forced to zero passes the base color through.
      l1_ctx_ff   <= sctx_ff[DIV_LAT-1];
      l1_ratio_ff <= sctx_ff[DIV_LAT-1].blend ? rat_quot : '0;
      l1_prod_ff  <= wide_type'(sctx_ff[DIV_LAT-1].bmax) * wide_type'(sat_quot);
      l2_ctx_ff   <= l2_ctx_in;
      l2_bmin_ff  <= l1_ctx_ff.bmin;
      l2_nspan_ff <= l1_ctx_ff.bmax - l2_ctx_in.lo;
      l3_ctx_ff   <= l2_ctx_ff;
      l3_prod_ff  <= l3_prod_in;
      l3_span_ff  <= l2_ctx_ff.bmax - l2_bmin_ff;
   end

   // ---------------------------------------------------------------- remap division
   logic [2:0]     rmp_valid;
   chan_type [2:0] rmp_quot;
   chan_type       rmp_den;
   mix_ctx_type    mctx_ff [DIV_LAT];

   assign rmp_den = l3_ctx_ff.grey ? chan_type'(1) : l3_span_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_remap
      hslb_div u_div_remap (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (l3_valid_ff),
         .in_num    (l3_prod_ff[gi] + wide_type'(l3_span_ff >> 1)),
         .in_den    (rmp_den),
         .out_valid (rmp_valid[gi]),
         .out_quot  (rmp_quot[gi])
      );
   end

   always_ff @(posedge clock) begin
      mctx_ff[0] <= l3_ctx_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         mctx_ff[k] <= mctx_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- blend
   pix_type out_pix;

   hslb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (&rmp_valid),
      .in_ctx    (mctx_ff[DIV_LAT-1]),
      .in_quot   (rmp_quot),
      .out_valid (rsp_valid),
      .out_pix   (out_pix)
   );

   assign rsp_result_red   = out_pix.red;
   assign rsp_result_green = out_pix.green;
   assign rsp_result_blue  = out_pix.blue;
   assign rsp_result_alpha = out_pix.alpha;
   assign rsp_run_last     = out_pix.last;

endmodule

`default_nettype wire

### hdl/hslb_checker.sv
// Port-level checks for the saturation layer blend unit, bound to its top level.
// Depends on hslb_pkg for the pipeline latency.
`default_nettype none

module hslb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_base_alpha,
   input logic        req_end_of_run,
   input logic        rsp_valid,
   input logic [15:0] rsp_result_alpha,
   input logic        rsp_run_last
);
   import hslb_pkg::*;

   // Every accepted transfer yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("accepted pixel produced no result");

   // No result appears without a matching accepted transfer.
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("result without an accepted pixel");

   // Alpha passes through with its pixel.
   a_alpha_kept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT (rsp_result_alpha == $past(req_base_alpha, PIPE_LAT)))
      else $error("result alpha does not match base alpha");

   // The run marker stays with its pixel.
   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT (rsp_run_last == $past(req_end_of_run, PIPE_LAT)))
      else $error("run marker out of step");

endmodule

bind hsv_saturation_layer_blend_unit hslb_checker u_hslb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_base_alpha   (req_base_alpha),
   .req_end_of_run   (req_end_of_run),
   .rsp_valid        (rsp_valid),
   .rsp_result_alpha (rsp_result_alpha),
   .rsp_run_last     (rsp_run_last)
);

`default_nettype wire

### verif/hsv_saturation_layer_blend_checker.sv
// Checker for the saturation layer blend unit: watches pixel and result transfers,
// predicts each blended pixel and compares it. Depends on hslb_pkg.
`timescale 1ns / 100ps

module hsv_saturation_layer_blend_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_base_red,
   input  logic [15:0] req_base_green,
   input  logic [15:0] req_base_blue,
   input  logic [15:0] req_base_alpha,
   input  logic [15:0] req_layer_red,
   input  logic [15:0] req_layer_green,
   input  logic [15:0] req_layer_blue,
   input  logic [15:0] req_layer_alpha,
   input  logic [15:0] req_mask_value,
   input  logic        req_end_of_run,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_result_red,
   input  logic [15:0] rsp_result_green,
   input  logic [15:0] rsp_result_blue,
   input  logic [15:0] rsp_result_alpha,
   input  logic        rsp_run_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   import hslb_pkg::*;

   localparam logic [2:0] ADDR_OPACITY = 3'd0;
   localparam logic [2:0] ADDR_MASK_EN = 3'd4;
   localparam longint     ONE = 65535;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        last;
   } blend_pixel_type;

   blend_pixel_type expected_pixels[$];
   logic [15:0]     opacity_shadow;
   logic            mask_shadow;

   function automatic longint fmul(input longint a, input longint b);
      return (a * b + ONE / 2) / ONE;
   endfunction

   // Blended pixel for one input transfer under the current register settings.
   function automatic blend_pixel_type blend_pixel(
      input longint br, input longint bg, input longint bb, input longint ba,
      input longint lr, input longint lg, input longint lb, input longint la,
      input longint msk, input logic last);
      blend_pixel_type p;
      longint base[3];
      longint hsv[3];
      longint comp, nal, ratio, lmax, lmin, bmax, bmin, sat, lo;
      base[0] = br; base[1] = bg; base[2] = bb;
      comp = fmul((ba < la) ? ba : la, opacity_shadow);
      if (mask_shadow) comp = fmul(comp, msk);
      nal = ba + fmul(ONE - ba, comp);
      if (comp != 0 && nal != 0) begin
         ratio = (comp * ONE + nal / 2) / nal;
         if (ratio > ONE) ratio = ONE;
         lmax = lr; if (lg > lmax) lmax = lg; if (lb > lmax) lmax = lb;
         lmin = lr; if (lg < lmin) lmin = lg; if (lb < lmin) lmin = lb;
         bmax = br; if (bg > bmax) bmax = bg; if (bb > bmax) bmax = bb;
         bmin = br; if (bg < bmin) bmin = bg; if (bb < bmin) bmin = bb;
         sat = (lmax != 0) ? ((lmax - lmin) * ONE + lmax / 2) / lmax : 0;
         lo = bmax - fmul(bmax, sat);
         for (int i = 0; i < 3; i++) begin
            // A grey base pixel is taken to have a red hue.
            if (bmax == bmin) hsv[i] = (i == 0) ? bmax : lo;
            else if (base[i] >= bmax) hsv[i] = bmax;
            else if (base[i] <= bmin) hsv[i] = lo;
            else hsv[i] = lo + ((bmax - lo) * (base[i] - bmin) + (bmax - bmin) / 2)
                               / (bmax - bmin);
            base[i] = (hsv[i] * ratio + base[i] * (ONE - ratio) + ONE / 2) / ONE;
         end
      end
      p.red = base[0][15:0];
      p.green = base[1][15:0];
      p.blue = base[2][15:0];
      p.alpha = ba[15:0];
      p.last = last;
      return p;
   endfunction

   // Track register writes, queue predictions and compare results.
   always @(posedge clock) begin
      blend_pixel_type e;
      int errs;
      errs = 0;
      if (reset) begin
         opacity_shadow <= 16'hFFFF;
         mask_shadow <= 1'b0;
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_OPACITY) opacity_shadow <= pwdata[15:0];
            else if (paddr == ADDR_MASK_EN) mask_shadow <= pwdata[0];
         end
         if (start && !busy)
            expected_pixels.push_back(blend_pixel(req_base_red, req_base_green,
               req_base_blue, req_base_alpha, req_layer_red, req_layer_green,
               req_layer_blue, req_layer_alpha, req_mask_value, req_end_of_run));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (expected_pixels.size() == 0) begin
               $error("result transfer with no pixel outstanding");
               errs++;
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_result_red !== e.red) begin
                  $error("result_red expected %0d got %0d", e.red, rsp_result_red);
                  errs++;
               end
               if (rsp_result_green !== e.green) begin
                  $error("result_green expected %0d got %0d", e.green, rsp_result_green);
                  errs++;
               end
               if (rsp_result_blue !== e.blue) begin
                  $error("result_blue expected %0d got %0d", e.blue, rsp_result_blue);
                  errs++;
               end
               if (rsp_result_alpha !== e.alpha) begin
                  $error("result_alpha expected %0d got %0d", e.alpha, rsp_result_alpha);
                  errs++;
               end
               if (rsp_run_last !== e.last) begin
                  $error("run_last expected %0d got %0d", e.last, rsp_run_last);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_pixels.size();
      end
   end

endmodule

### verif/tb_hsv_saturation_layer_blend_unit.sv
// Testbench top for the saturation layer blend unit: drives pixels and register
// writes, gives the verdict. Depends on hslb_pkg and hsv_saturation_layer_blend_checker.
`timescale 1ns / 100ps

module tb_hsv_saturation_layer_blend_unit;
   import hslb_pkg::*;

   localparam logic [2:0] ADDR_OPACITY = 3'd0;
   localparam logic [2:0] ADDR_MASK_EN = 3'd4;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] base_red = '0, base_green = '0, base_blue = '0, base_alpha = '0;
   logic [15:0] layer_red = '0, layer_green = '0, layer_blue = '0, layer_alpha = '0;
   logic [15:0] mask_value = '0;
   logic        end_of_run = 1'b0;
   logic        rsp_valid;
   logic [15:0] rsp_result_red, rsp_result_green, rsp_result_blue, rsp_result_alpha;
   logic        rsp_run_last;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending_count, result_count;
   int          cycle_count = 0;
   int          pixel_count = 0;

   always #1 clock = ~clock;

   hsv_saturation_layer_blend_unit uut (
      .clock, .reset, .start, .busy,
      .req_base_red(base_red), .req_base_green(base_green),
      .req_base_blue(base_blue), .req_base_alpha(base_alpha),
      .req_layer_red(layer_red), .req_layer_green(layer_green),
      .req_layer_blue(layer_blue), .req_layer_alpha(layer_alpha),
      .req_mask_value(mask_value), .req_end_of_run(end_of_run),
      .rsp_valid, .rsp_result_red, .rsp_result_green, .rsp_result_blue,
      .rsp_result_alpha, .rsp_run_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   hsv_saturation_layer_blend_checker checker_i (
      .clock, .reset, .start, .busy,
      .req_base_red(base_red), .req_base_green(base_green),
      .req_base_blue(base_blue), .req_base_alpha(base_alpha),
      .req_layer_red(layer_red), .req_layer_green(layer_green),
      .req_layer_blue(layer_blue), .req_layer_alpha(layer_alpha),
      .req_mask_value(mask_value), .req_end_of_run(end_of_run),
      .rsp_valid, .rsp_result_red, .rsp_result_green, .rsp_result_blue,
      .rsp_result_alpha, .rsp_run_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending_count, .result_count
   );

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[hsv_saturation_layer_blend_unit] ERROR");
         $finish;
      end
   end

   // Setup and access cycles of one register write.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Present one pixel and hold it until the transfer; optionally idle afterwards.
   task automatic send_pixel(input logic [15:0] br, bg, bb, ba, lr, lg, lb, la, mv,
                             input logic last, input bit allow_gap);
      int gap;
      base_red <= br; base_green <= bg; base_blue <= bb; base_alpha <= ba;
      layer_red <= lr; layer_green <= lg; layer_blue <= lb; layer_alpha <= la;
      mask_value <= mv; end_of_run <= last; start <= 1'b1;
      do @(posedge clock); while (busy);
      pixel_count++;
      gap = 0;
      if (allow_gap) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 15));
         3:       return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   // Drain all outstanding results, then wait out the pipeline.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   task automatic random_pixels(input int count);
      logic [15:0] g;
      for (int n = 0; n < count; n++) begin
         g = pick_channel();
         if ($urandom_range(0, 7) == 0)
            // Base pixel with tied red and green, grey when blue ties too.
            send_pixel(g, g, ($urandom_range(0, 1) == 1) ? g : pick_channel(), pick_channel(),
                       pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       pick_channel(), ($urandom_range(0, 1) == 1), 1'b1);
         else
            send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       pick_channel(), ($urandom_range(0, 15) == 0), 1'b1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels at reset settings: extremes, grey base, black layer, zero alpha.
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      send_pixel(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF,
                 0, 1'b0, 1'b0);
      send_pixel(16'h9000, 16'h4000, 16'h1000, 16'h8000, 0, 0, 0, 16'hFFFF, 0, 1'b0, 1'b0);
      send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h1234, 16'hFFFF, 16'h0000,
                 16'h0001, 16'h5555, 1'b1, 1'b0);
      send_pixel(16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                 16'hFFFF, 16'hAAAA, 1'b0, 1'b0);
      send_pixel(16'h2000, 16'h7000, 16'hC000, 16'hFFFF, 16'h3000, 16'h3000, 16'h3000,
                 16'h0000, 16'hFFFF, 1'b0, 1'b0);
      send_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0001, 16'hFFFE, 16'h0001, 16'h7FFF,
                 16'h0001, 16'h0000, 1'b1, 1'b0);
      drain_pipeline();

      // Masked with opacity extremes.
      write_register(ADDR_MASK_EN, 32'h1);
      write_register(ADDR_OPACITY, 32'h0);
      send_pixel(16'h9000, 16'h4000, 16'h1000, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF,
                 16'hFFFF, 1'b0, 1'b0);
      drain_pipeline();
      write_register(ADDR_OPACITY, 32'hFFFF);
      send_pixel(16'h9000, 16'h4000, 16'h1000, 16'h4000, 16'hFFFF, 0, 0, 16'hFFFF,
                 16'h0000, 1'b0, 1'b0);
      send_pixel(16'h9000, 16'h4000, 16'h1000, 16'h0000, 16'hFFFF, 16'h8000, 0, 16'hFFFF,
                 16'hFFFF, 1'b1, 1'b0);
      send_pixel(16'h0001, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001, 16'h0002, 16'hFFFF,
                 16'h0001, 16'h0001, 1'b0, 1'b0);
      drain_pipeline();

      // Random phases across register settings; stray upper bits probe masking.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_register(ADDR_OPACITY, 32'hFFFF);
            1: write_register(ADDR_OPACITY, 32'h0000);
            2: write_register(ADDR_OPACITY, 32'hABCD_0001);
            default: write_register(ADDR_OPACITY, $urandom);
         endcase
         write_register(ADDR_MASK_EN, (phase % 2 == 0) ? 32'hFFFF_FFFE : 32'h1);
         random_pixels((phase == 1) ? 60 : 155);
         drain_pipeline();
      end

      $display("Covered %0d pixels with %0d results over eleven register settings,",
               pixel_count, result_count);
      $display("including grey and tied base pixels, black layers and zero alphas.");
      if (fail_count == 0) begin
         $display("[hsv_saturation_layer_blend_unit] OK");
      end else begin
         $display("[hsv_saturation_layer_blend_unit] ERROR");
      end
      $finish;
   end

endmodule
